// ----- rtl/core/tdq_pkg.sv -----
// shared types and constants for the tick deadline queue
package tdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 32;
    localparam int RCNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [19:0] MICRO_MAX = 20'd999999;
    localparam logic [20:0] MICRO_PER_SEC = 21'd1000000;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_INS_INTERVAL = 2'd1;
    localparam logic [1:0] CMD_INS_ABSOLUTE = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] KIND_INTERVAL = 2'd0;
    localparam logic [1:0] KIND_ABSOLUTE = 2'd1;
    localparam logic [1:0] KIND_ACCEPTED = 2'd2;
    localparam logic [1:0] KIND_FULL = 2'd3;

    localparam logic CFG_TICK_MICRO = 1'b0;
    localparam logic CFG_TICK_SECS = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  id;
        logic [31:0] secs;
        logic [19:0] micro;
    } job_t;

    typedef struct packed {
        logic [31:0] secs;
        logic [19:0] micro;
        logic [7:0]  id;
    } entry_t;

    // strictly earlier deadline
    function automatic logic is_before(logic [31:0] ds, logic [19:0] dm,
                                       logic [31:0] cs, logic [19:0] cm);
        is_before = (ds < cs) || ((ds == cs) && (dm < cm));
    endfunction

endpackage

// ----- rtl/core/tdq_front.sv -----
// front end: takes commands and holds them in a short queue
module tdq_front
    import tdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  cmd,
    input  logic [7:0]  request_id,
    input  logic [31:0] deadline_secs,
    input  logic [19:0] deadline_micro,
    output logic        busy,
    input  logic        pop,
    output logic        job_valid,
    output job_t        job
);

    // two-entry queue
    job_t       slot_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;

    // unused command code is dropped here
    assign push = start && !busy && (cmd != CMD_NONE);
    assign busy = (fill_reg == 2'd2);
    assign job_valid = (fill_reg != 2'd0);
    assign job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && job_valid)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop && job_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{cmd: cmd, id: request_id,
                                      secs: deadline_secs, micro: deadline_micro};
        end
    end

endmodule

// ----- rtl/core/tdq_sorted_queue.sv -----
// one deadline-sorted queue as a shift array with per-slot compare
module tdq_sorted_queue
    import tdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ins,
    input  entry_t            ins_entry,
    input  logic              pop_head,
    output entry_t            head,
    output logic [QCNT_W-1:0] count,
    output logic              full
);

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QCNT_W-1:0] count_reg;
    logic [QUEUE_DEPTH-1:0] go_after;

    assign head = slot_reg[0];
    assign count = count_reg;
    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));

    // new entry goes after every valid slot not later than it
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            go_after[i] = (QCNT_W'(i) < count_reg) &&
                !is_before(ins_entry.secs, ins_entry.micro,
                           slot_reg[i].secs, slot_reg[i].micro);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ins && !full)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (pop_head && count_reg != '0)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (ins && !full)
            begin
                if (!go_after[i])
                begin
                    if (i == 0 || go_after[(i == 0) ? 0 : i - 1])
                    begin
                        slot_reg[i] <= ins_entry;
                    end
                    else
                    begin
                        slot_reg[i] <= slot_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
            else if (pop_head && i < QUEUE_DEPTH - 1)
            begin
                slot_reg[i] <= slot_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

endmodule

// ----- rtl/core/tdq_back.sv -----
// back end: clocks, retirement sequencer and result register
module tdq_back
    import tdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        pop,
    input  logic [19:0] tick_micro,
    input  logic [7:0]  tick_secs,
    output logic        done,
    output logic [1:0]  kind,
    output logic [7:0]  done_id,
    output logic        last,
    output logic [31:0] now_secs,
    output logic [19:0] now_micro
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INT = 2'd1;
    localparam logic [1:0] ST_ABS = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] cur_secs_reg, ela_secs_reg, tick_count_reg;
    logic [19:0] cur_micro_reg, ela_micro_reg;
    logic [RCNT_W-1:0] nres_reg;
    logic        done_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  id_reg;
    logic        last_reg;

    entry_t int_head, abs_head, ins_entry;
    logic [QCNT_W-1:0] int_count, abs_count;
    logic int_full, abs_full, int_ins, abs_ins, int_pop, abs_pop;
    logic int_due, abs_due, room;
    logic [31:0] cur_secs_add, ela_secs_add;
    logic [19:0] cur_micro_add, ela_micro_add, step_micro;
    logic [20:0] cm_sum, em_sum;

    assign ins_entry = '{secs: job.secs, micro: job.micro, id: job.id};
    assign pop = (state_reg == ST_IDLE) && job_valid;
    assign int_ins = pop && (job.cmd == CMD_INS_INTERVAL);
    assign abs_ins = pop && (job.cmd == CMD_INS_ABSOLUTE);

    tdq_sorted_queue u_int (
        .clk(clk), .rst_n(rst_n), .ins(int_ins), .ins_entry(ins_entry),
        .pop_head(int_pop), .head(int_head), .count(int_count), .full(int_full)
    );
    tdq_sorted_queue u_abs (
        .clk(clk), .rst_n(rst_n), .ins(abs_ins), .ins_entry(ins_entry),
        .pop_head(abs_pop), .head(abs_head), .count(abs_count), .full(abs_full)
    );

    // clock advance with microsecond carry
    assign step_micro = (tick_micro > MICRO_MAX) ? MICRO_MAX : tick_micro;
    assign cm_sum = {1'b0, cur_micro_reg} + {1'b0, step_micro};
    assign em_sum = {1'b0, ela_micro_reg} + {1'b0, step_micro};
    always_comb
    begin
        cur_secs_add = cur_secs_reg + {24'd0, tick_secs};
        ela_secs_add = ela_secs_reg + {24'd0, tick_secs};
        cur_micro_add = cm_sum[19:0];
        ela_micro_add = em_sum[19:0];
        if (cm_sum > {1'b0, MICRO_MAX})
        begin
            cur_secs_add = cur_secs_add + 32'd1;
            cur_micro_add = 20'(cm_sum - MICRO_PER_SEC);
        end
        if (em_sum > {1'b0, MICRO_MAX})
        begin
            ela_secs_add = ela_secs_add + 32'd1;
            ela_micro_add = 20'(em_sum - MICRO_PER_SEC);
        end
    end

    assign room = (nres_reg < RCNT_W'(MAX_RESULTS));
    assign int_due = room && (int_count != '0) &&
        is_before(int_head.secs, int_head.micro, ela_secs_reg, ela_micro_reg);
    assign abs_due = room && (abs_count != '0) &&
        is_before(abs_head.secs, abs_head.micro, cur_secs_reg, cur_micro_reg);
    assign int_pop = (state_reg == ST_INT) && int_due;
    assign abs_pop = (state_reg == ST_ABS) && abs_due;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && job.cmd == CMD_TICK)
                begin
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                if (!int_due)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                if (!abs_due)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // results are held in a pending stage so last can be known
    logic       pend_reg;
    logic [1:0] pend_kind_reg;
    logic [7:0] pend_id_reg;
    logic       new_res, end_job;
    logic [1:0] new_kind;
    logic [7:0] new_id;
    logic       done_next, last_next;

    always_comb
    begin
        new_res = 1'b0;
        new_kind = KIND_INTERVAL;
        new_id = 8'd0;
        end_job = 1'b0;
        if (int_ins || abs_ins)
        begin
            new_res = 1'b1;
            new_kind = (int_ins ? int_full : abs_full) ? KIND_FULL : KIND_ACCEPTED;
            new_id = job.id;
            end_job = 1'b1;
        end
        else if (int_pop)
        begin
            new_res = 1'b1;
            new_kind = KIND_INTERVAL;
            new_id = int_head.id;
        end
        else if (abs_pop)
        begin
            new_res = 1'b1;
            new_kind = KIND_ABSOLUTE;
            new_id = abs_head.id;
        end
        else if (state_reg == ST_ABS)
        begin
            end_job = 1'b1;
        end
    end

    // pending result leaves when a newer one arrives or the job ends
    always_comb
    begin
        done_next = 1'b0;
        last_next = 1'b0;
        if (int_ins || abs_ins)
        begin
            done_next = 1'b1;
            last_next = 1'b1;
        end
        else if (pend_reg && (new_res || end_job))
        begin
            done_next = 1'b1;
            last_next = end_job && !new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_secs_reg <= '0;
            cur_micro_reg <= '0;
            ela_secs_reg <= '0;
            ela_micro_reg <= '0;
            tick_count_reg <= '0;
            nres_reg <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && job.cmd == CMD_TICK)
            begin
                cur_secs_reg <= cur_secs_add;
                cur_micro_reg <= cur_micro_add;
                ela_secs_reg <= ela_secs_add;
                ela_micro_reg <= ela_micro_add;
                tick_count_reg <= tick_count_reg + 32'd1;
                nres_reg <= '0;
            end
            else if (int_pop || abs_pop)
            begin
                nres_reg <= nres_reg + 1'b1;
            end
            done_reg <= done_next;
            last_reg <= last_next;
            if (int_ins || abs_ins)
            begin
                pend_reg <= 1'b0;
            end
            else if (new_res)
            begin
                pend_reg <= 1'b1;
            end
            else if (end_job)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (int_ins || abs_ins)
        begin
            kind_reg <= new_kind;
            id_reg <= new_id;
        end
        else if (pend_reg && (new_res || end_job))
        begin
            kind_reg <= pend_kind_reg;
            id_reg <= pend_id_reg;
        end
        if (new_res)
        begin
            pend_kind_reg <= new_kind;
            pend_id_reg <= new_id;
        end
    end

    assign done = done_reg;
    assign kind = kind_reg;
    assign done_id = id_reg;
    assign last = last_reg;
    assign now_secs = cur_secs_reg;
    assign now_micro = cur_micro_reg;

endmodule

// ----- rtl/core/tick_deadline_queue.sv -----
// top level of the tick deadline queue
// the sequencer in the back end retires one queue head per cycle, interval
// queue first, and the front queue holds two commands so start is taken while
// the back end works, until both slots are full. results appear on done for one
// cycle each and cannot be held off; kind, done_id and last are valid with done,
// now_secs and now_micro show the current clock. configuration writes are always
// ready.
module tick_deadline_queue
    import tdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  request_id,
    input  logic [31:0] deadline_secs,
    input  logic [19:0] deadline_micro,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    output logic        done,
    output logic [1:0]  kind,
    output logic [7:0]  done_id,
    output logic        last,
    output logic [31:0] now_secs,
    output logic [19:0] now_micro
);

    logic [19:0] tick_micro_reg;
    logic [7:0]  tick_secs_reg;
    logic        job_valid, pop;
    job_t        job;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_micro_reg <= 20'd20000;
            tick_secs_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TICK_MICRO: tick_micro_reg <= cfg_data;
                CFG_TICK_SECS: tick_secs_reg <= cfg_data[7:0];
                default: tick_secs_reg <= tick_secs_reg;
            endcase
        end
    end

    tdq_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .request_id(request_id), .deadline_secs(deadline_secs),
        .deadline_micro(deadline_micro), .busy(busy), .pop(pop),
        .job_valid(job_valid), .job(job)
    );

    tdq_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job), .pop(pop),
        .tick_micro(tick_micro_reg), .tick_secs(tick_secs_reg),
        .done(done), .kind(kind), .done_id(done_id), .last(last),
        .now_secs(now_secs), .now_micro(now_micro)
    );

endmodule

// ----- rtl/core/tdq_checker.sv -----
// port-level checks for the tick deadline queue
module tdq_port_props
    import tdq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic        last,
    input logic [1:0]  kind,
    input logic [19:0] now_micro,
    input logic        cfg_ready
);

    a_micro_range: assert property (@(posedge clk) disable iff (!rst_n)
        now_micro <= MICRO_MAX) else $error("clock micro out of range");

    a_last_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> done) else $error("last without result");

    a_insert_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && (kind == KIND_ACCEPTED || kind == KIND_FULL) |-> last)
        else $error("insert result not last");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready) else $error("config not ready");

endmodule

bind tick_deadline_queue tdq_port_props u_tdq_port_props (
    .clk(clk), .rst_n(rst_n), .done(done), .last(last), .kind(kind),
    .now_micro(now_micro), .cfg_ready(cfg_ready)
);

// ----- bench/tdq_checker.sv -----
// checker for the tick deadline queue: timer and queue model, result compare
module tdq_checker
    import tdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  request_id,
    input  logic [31:0] deadline_secs,
    input  logic [19:0] deadline_micro,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        done,
    input  logic [1:0]  kind,
    input  logic [7:0]  done_id,
    input  logic        last,
    input  logic [31:0] now_secs,
    input  logic [19:0] now_micro,
    output int          pending,
    output int          fail_count
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic        last;
        logic [31:0] secs;
        logic [19:0] micro;
    } outcome_t;

    outcome_t    outcomes[$];
    logic [19:0] period_micro;
    logic [7:0]  period_secs;
    logic [31:0] cur_secs, ela_secs, tick_total;
    logic [19:0] cur_micro, ela_micro;
    entry_t      ival_q[QUEUE_DEPTH];
    entry_t      abs_q[QUEUE_DEPTH];
    int          ival_n, abs_n;

    assign pending = outcomes.size();

    function automatic logic earlier(logic [31:0] ds, logic [19:0] dm,
                                     logic [31:0] cs, logic [19:0] cm);
        return (ds < cs) || ((ds == cs) && (dm < cm));
    endfunction

    task automatic advance(inout logic [31:0] s, inout logic [19:0] m);
        logic [20:0] sum;
        sum = (period_micro > MICRO_MAX ? MICRO_MAX : period_micro) + m;
        s = s + period_secs;
        if (sum > MICRO_MAX)
        begin
            s = s + 1;
            sum = sum - MICRO_PER_SEC;
        end
        m = sum[19:0];
    endtask

    task automatic note(logic [1:0] k, logic [7:0] id);
        outcome_t o;
        o = '{kind: k, id: id, last: 1'b0, secs: cur_secs, micro: cur_micro};
        outcomes.push_back(o);
    endtask

    task automatic predict_tick();
        int n;
        n = 0;
        advance(cur_secs, cur_micro);
        advance(ela_secs, ela_micro);
        tick_total = tick_total + 1;
        while (n < MAX_RESULTS && ival_n > 0 &&
               earlier(ival_q[0].secs, ival_q[0].micro, ela_secs, ela_micro))
        begin
            note(KIND_INTERVAL, ival_q[0].id);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                ival_q[i] = ival_q[i + 1];
            ival_n--;
            n++;
        end
        while (n < MAX_RESULTS && abs_n > 0 &&
               earlier(abs_q[0].secs, abs_q[0].micro, cur_secs, cur_micro))
        begin
            note(KIND_ABSOLUTE, abs_q[0].id);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                abs_q[i] = abs_q[i + 1];
            abs_n--;
            n++;
        end
        if (n > 0)
            outcomes[outcomes.size() - 1].last = 1'b1;
    endtask

    task automatic place(inout entry_t q[QUEUE_DEPTH], inout int cnt, input entry_t e);
        int pos;
        pos = 0;
        if (cnt >= QUEUE_DEPTH)
        begin
            note(KIND_FULL, e.id);
        end
        else
        begin
            while (pos < cnt && !earlier(e.secs, e.micro, q[pos].secs, q[pos].micro))
                pos++;
            for (int i = QUEUE_DEPTH - 1; i > pos; i--)
                q[i] = q[i - 1];
            q[pos] = e;
            cnt++;
            note(KIND_ACCEPTED, e.id);
        end
        outcomes[outcomes.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outcomes.delete();
            period_micro = 20'd20000;
            period_secs = 8'd0;
            cur_secs = '0;
            cur_micro = '0;
            ela_secs = '0;
            ela_micro = '0;
            tick_total = '0;
            ival_n = 0;
            abs_n = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TICK_MICRO)
                    period_micro = cfg_data;
                else
                    period_secs = cfg_data[7:0];
            end
            if (start && !busy)
            begin
                if (cmd == CMD_TICK)
                    predict_tick();
                else if (cmd == CMD_INS_INTERVAL)
                    place(ival_q, ival_n, '{deadline_secs, deadline_micro, request_id});
                else if (cmd == CMD_INS_ABSOLUTE)
                    place(abs_q, abs_n, '{deadline_secs, deadline_micro, request_id});
            end
            if (done)
            begin
                if (outcomes.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual kind %0d id %0d",
                             $time, kind, done_id);
                    fail_count++;
                end
                else if (outcomes[0] != {kind, done_id, last, now_secs, now_micro})
                begin
                    $display("%0t mismatch: expected kind %0d id %0d last %0d now %0d.%06d",
                             $time, outcomes[0].kind, outcomes[0].id, outcomes[0].last,
                             outcomes[0].secs, outcomes[0].micro);
                    $display("%0t           actual kind %0d id %0d last %0d now %0d.%06d",
                             $time, kind, done_id, last, now_secs, now_micro);
                    fail_count++;
                    void'(outcomes.pop_front());
                end
                else
                begin
                    void'(outcomes.pop_front());
                end
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
// top of the tick deadline queue bench: stimulus, phases and verdict
module testbench;
    import tdq_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = CMD_TICK;
    logic [7:0]  request_id = '0;
    logic [31:0] deadline_secs = '0;
    logic [19:0] deadline_micro = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_TICK_MICRO;
    logic [19:0] cfg_data = '0;
    logic        done;
    logic [1:0]  kind;
    logic [7:0]  done_id;
    logic        last;
    logic [31:0] now_secs;
    logic [19:0] now_micro;
    int          pending;
    int          fail_count;
    int          cycles = 0;

    // tick period and idle percentage the stimulus steers by
    int unsigned period_us;
    int          idle_pct;

    localparam int RANDOM_ITEMS = 210;
    localparam int SETTLE = 60;
    localparam int CYCLE_LIMIT = 200000;

    tick_deadline_queue uut (.*);

    tdq_checker chk (.*);

    always #5 clk = ~clk;

    // overall watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // present one item and hold it until the block takes it; start stays high
    task automatic issue(logic [1:0] c, logic [7:0] id, logic [31:0] s, logic [19:0] m);
        start <= 1'b1;
        cmd <= c;
        request_id <= id;
        deadline_secs <= s;
        deadline_micro <= m;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random sender gaps between items
    task automatic pause();
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // wait for every outstanding result, then let any quiet tick drain
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write both period registers back to back while idle
    task automatic set_period(logic [19:0] us, logic [7:0] s);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TICK_MICRO;
        cfg_data <= us;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_TICK_SECS;
        cfg_data <= {12'd0, s};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        period_us = s * 1000000 + (us > MICRO_MAX ? MICRO_MAX : us);
    endtask

    // one random item; deadlines mostly land a few ticks ahead of the clock
    task automatic random_item();
        int unsigned r;
        longint unsigned at;
        logic [1:0] c;
        logic [31:0] s;
        logic [19:0] m;
        r = $urandom_range(0, 99);
        c = (r < 40) ? CMD_INS_INTERVAL : (r < 70) ? CMD_INS_ABSOLUTE :
            (r < 95) ? CMD_TICK : CMD_NONE;
        if ($urandom_range(0, 9) == 0)
        begin
            s = $urandom();
            m = 20'($urandom_range(0, 20'hFFFFF));
        end
        else
        begin
            at = longint'(now_secs) * 1000000 + now_micro
                 + $urandom_range(0, 5 * period_us + 1000);
            s = 32'(at / 1000000);
            m = 20'(at % 1000000);
        end
        issue(c, 8'($urandom_range(0, 255)), s, m);
    endtask

    initial
    begin
        period_us = 20000;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: quiet tick, unused command, far deadline, retire one
        issue(CMD_TICK, 8'd0, 32'd0, 20'd0);
        issue(CMD_NONE, 8'd7, 32'hFFFF_FFFF, 20'hFFFFF);
        issue(CMD_INS_ABSOLUTE, 8'd255, 32'hFFFF_FFFF, MICRO_MAX);
        issue(CMD_INS_INTERVAL, 8'd0, 32'd0, 20'd0);
        issue(CMD_TICK, 8'd0, 32'd0, 20'd0);
        // fill the interval queue with tied deadlines, one oversized micro, then overflow
        for (int i = 0; i < QUEUE_DEPTH; i++)
            issue(CMD_INS_INTERVAL, 8'(i + 1), 32'd0,
                  (i == QUEUE_DEPTH - 1) ? 20'hFFFFF : 20'((i % 4) * 15000));
        issue(CMD_INS_INTERVAL, 8'd99, 32'd1, 20'd0);
        issue(CMD_TICK, 8'd0, 32'd0, 20'd0);
        settle();

        // random phases, each under its own tick period; extremes and oversized period
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 42 == 0)
            begin
                settle();
                case (k / 42)
                    0: set_period(20'd250000, 8'd0);
                    1: set_period(MICRO_MAX, 8'd255);
                    2: set_period(20'hFFFFF, 8'd1);
                    3: set_period(20'd0, 8'd0);
                    default: set_period(20'd300000, 8'd2);
                endcase
            end
            idle_pct = (k < 70) ? 22 : (k < 140) ? 46 : 0;
            random_item();
            pause();
        end

        settle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tdq_pkg.sv
rtl/core/tdq_front.sv
rtl/core/tdq_sorted_queue.sv
rtl/core/tdq_back.sv
rtl/core/tick_deadline_queue.sv
rtl/core/tdq_checker.sv
bench/tdq_checker.sv
bench/testbench.sv
